// ===== rtl/fjs_string_search_macros.svh =====
// Assertion macros used by the string search module
`ifndef FJS_STRING_SEARCH_MACROS_SVH
`define FJS_STRING_SEARCH_MACROS_SVH

// Implication checked every clock, idle in reset
`define FJS_ASSERT_IMP(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define FJS_ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/fjs_pkg.sv =====
// ----------------------------------------------------------------------------
// fjs_pkg
// Request and result types and request codes for the string search block.
// ----------------------------------------------------------------------------
package fjs_pkg;

	localparam logic [1:0] REQ_PAT   = 2'd0;
	localparam logic [1:0] REQ_TEXT  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_FIND  = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [5:0] pattern_index;
		logic [7:0] data_byte;
	} fjs_req_t;

	typedef struct packed {
		logic        found;
		logic [11:0] match_pos;
		logic        exhausted;
		logic        text_overflow;
	} fjs_res_t;

endpackage

// ===== rtl/fjs_ram.sv =====
// ----------------------------------------------------------------------------
// fjs_ram
// Generic single-port RAM, one write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
module fjs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/fjs_string_search.sv =====
// ----------------------------------------------------------------------------
// fjs_string_search
// Exact pattern search by the FJS hybrid (quick-search skip plus KMP check).
// ----------------------------------------------------------------------------
// channel | signals                    | timing
// request | start, busy, req           | accepted when start & !busy
// result  | res_valid, res             | one-cycle strobe, never stalled
// config  | psel..pready (APB)          | write while idle
//
// Pattern write, text append and clear go through ST_RESP, which registers the
// result strobe. Find: a sequencer reads the RAMs one step at a time; the first
// find after a pattern or length change first rebuilds the shift table and then
// the failure table, following failure links as needed. Each window checks its
// last byte, then either skips by the shift table or compares bytes from the
// start and shifts by the failure table. No clearing pass after reset.
module fjs_string_search
	import fjs_pkg::*;
#(
	parameter int PATTERN_MAX = 64,
	parameter int TEXT_MAX    = 4096,
	parameter int ALPHABET    = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  fjs_req_t req,
	output logic     res_valid,
	output fjs_res_t res,
	input  logic     psel,
	input  logic     penable,
	input  logic     pwrite,
	input  logic     paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic     pready
);
	`include "fjs_string_search_macros.svh"

	localparam int PW = $clog2(PATTERN_MAX + 2);   // holds 0..PATTERN_MAX+1
	localparam int PA = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int FA = $clog2(PATTERN_MAX + 1);
	localparam int TA = $clog2(TEXT_MAX);
	localparam int TW = TA + 1;
	localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int SW = TW + 1;                     // shift with headroom

	typedef enum logic [4:0] {
		ST_IDLE, ST_RESP,
		ST_BT_FILL, ST_BT_PAT, ST_BT_PATW,
		ST_KF_INIT, ST_KF_RDI, ST_KF_RDJ, ST_KF_CMP, ST_KF_RDF, ST_KF_FWAIT,
		ST_KF_STEP, ST_KF_RDI2, ST_KF_RDJ2, ST_KF_SET, ST_KF_FJ,
		ST_F_START, ST_F_LAST, ST_F_LASTW, ST_F_CHK, ST_F_NEXT, ST_F_SHW,
		ST_F_SHIFT, ST_F_CMP, ST_F_CMPW, ST_F_CMPD, ST_F_FAIL, ST_F_FAILW
	} state_t;

	state_t state_q;
	logic [PW-1:0] plen_q;
	logic [TW-1:0] tlen_q;
	logic [SW-1:0] shift_q;
	logic          valid_q;
	fjs_res_t      res_q;
	logic          resv_q;

	// Sequencer indices and holding registers
	logic [AW:0]   ai_q;
	logic [PW-1:0] i_q;
	logic [FA:0]   j_q;       // signed, -1 allowed
	logic [7:0]    bi_q;

	// RAM ports
	logic          p_we, t_we, s_we, f_we;
	logic [PA-1:0] p_addr;
	logic [TA-1:0] t_addr;
	logic [AW-1:0] s_addr;
	logic [FA-1:0] f_addr;
	logic [7:0]    p_wd, p_rd, t_wd, t_rd;
	logic [PW-1:0] s_wd, s_rd;
	logic [FA:0]   f_wd, f_rd;

	fjs_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pat (.clk(clk), .we(p_we),
		.addr(p_addr), .wdata(p_wd), .rdata(p_rd));
	fjs_ram #(.WIDTH(8), .DEPTH(TEXT_MAX)) u_txt (.clk(clk), .we(t_we),
		.addr(t_addr), .wdata(t_wd), .rdata(t_rd));
	fjs_ram #(.WIDTH(PW), .DEPTH(ALPHABET)) u_shf (.clk(clk), .we(s_we),
		.addr(s_addr), .wdata(s_wd), .rdata(s_rd));
	fjs_ram #(.WIDTH(FA + 1), .DEPTH(PATTERN_MAX + 1)) u_fail (.clk(clk),
		.we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

	logic [7:0]    byte_red;
	logic [SW-1:0] last_w;
	logic [SW-1:0] plen_x, tlen_x;
	logic          acc, cfg_wr;
	logic [6:0]    cfg_v;
	logic [PW-1:0] cfg_len;

	assign byte_red = 8'(req.data_byte % ALPHABET);
	assign plen_x   = SW'(plen_q);
	assign tlen_x   = SW'(tlen_q);
	assign last_w   = tlen_x - plen_x;
	assign acc      = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_v    = pwdata[6:0];
	assign pready   = 1'b1;
	assign prdata   = (paddr == 1'b0) ? 32'(plen_q) : 32'd0;
	assign res_valid = resv_q;
	assign res       = res_q;

	// Clamp a length write into 1..PATTERN_MAX
	always_comb begin
		if (cfg_v == 7'd0) cfg_len = PW'(1);
		else if (32'(cfg_v) > PATTERN_MAX) cfg_len = PW'(PATTERN_MAX);
		else cfg_len = PW'(cfg_v);
	end

	// RAM port steering by state
	always_comb begin
		p_we = 1'b0; t_we = 1'b0; s_we = 1'b0; f_we = 1'b0;
		p_addr = '0; t_addr = '0; s_addr = '0; f_addr = '0;
		p_wd = byte_red; t_wd = byte_red; s_wd = '0; f_wd = '0;
		case (state_q)
			ST_IDLE: begin
				p_addr = PA'(req.pattern_index);
				t_addr = tlen_q[TA-1:0];
				p_we = acc && (req.req_type == REQ_PAT) &&
					(32'(req.pattern_index) < PATTERN_MAX);
				t_we = acc && (req.req_type == REQ_TEXT) && (32'(tlen_q) < TEXT_MAX);
			end
			ST_BT_FILL: begin
				s_we = 1'b1; s_addr = ai_q[AW-1:0]; s_wd = plen_q + PW'(1);
			end
			ST_BT_PAT: p_addr = PA'(i_q);
			ST_BT_PATW: begin
				s_we = 1'b1; s_addr = AW'(p_rd % ALPHABET); s_wd = plen_q - i_q;
			end
			ST_KF_INIT: begin
				f_we = 1'b1; f_addr = '0; f_wd = '1;
			end
			ST_KF_RDI, ST_KF_RDI2: p_addr = PA'(i_q);
			ST_KF_RDJ, ST_KF_RDJ2: p_addr = PA'(j_q);
			ST_KF_RDF: f_addr = FA'(j_q);
			ST_KF_SET: begin
				f_we = 1'b1; f_addr = FA'(i_q); f_wd = j_q;
			end
			ST_KF_FJ: f_addr = FA'(j_q);
			ST_KF_STEP: begin
				f_we = 1'b1; f_addr = FA'(i_q); f_wd = f_rd;
			end
			// address driven in both ST_F_LAST and ST_F_LASTW so read data stays put for the check
			ST_F_LAST, ST_F_LASTW: begin
				p_addr = PA'(plen_q - PW'(1));
				t_addr = TA'(shift_q + plen_x - SW'(1));
			end
			ST_F_NEXT: t_addr = TA'(shift_q + plen_x);
			ST_F_SHW: s_addr = AW'(t_rd % ALPHABET);
			ST_F_CMP, ST_F_CMPW: begin
				p_addr = PA'(i_q); t_addr = TA'(shift_q + SW'(i_q));
			end
			ST_F_FAIL: f_addr = FA'(i_q);
			default: ;
		endcase
	end

	// Sequencer, state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plen_q  <= PW'(1);
			tlen_q  <= '0;
			shift_q <= '0;
			valid_q <= 1'b0;
			resv_q  <= 1'b0;
			res_q   <= '0;
			ai_q <= '0; i_q <= '0; j_q <= '0; bi_q <= '0;
		end else begin
			resv_q <= 1'b0;
			if (cfg_wr && paddr == 1'b0) begin
				plen_q  <= cfg_len;
				valid_q <= 1'b0;
				shift_q <= '0;
			end
			case (state_q)
				ST_IDLE: if (acc) begin
					res_q <= '0;
					case (req.req_type)
						REQ_PAT: begin
							if (32'(req.pattern_index) < PATTERN_MAX) begin
								valid_q <= 1'b0; shift_q <= '0;
							end
							state_q <= ST_RESP;
						end
						REQ_TEXT: begin
							if (32'(tlen_q) < TEXT_MAX) tlen_q <= tlen_q + TW'(1);
							else res_q.text_overflow <= 1'b1;
							state_q <= ST_RESP;
						end
						REQ_CLEAR: begin
							tlen_q <= '0; shift_q <= '0; state_q <= ST_RESP;
						end
						default: begin
							ai_q <= '0;
							state_q <= valid_q ? ST_F_START : ST_BT_FILL;
						end
					endcase
				end
				ST_RESP: begin
					resv_q <= 1'b1; state_q <= ST_IDLE;
				end
				// Shift table: fill then overwrite per pattern byte
				ST_BT_FILL: begin
					ai_q <= ai_q + (AW+1)'(1);
					if (32'(ai_q) == ALPHABET - 1) begin
						i_q <= '0; state_q <= ST_BT_PAT;
					end
				end
				ST_BT_PAT: state_q <= ST_BT_PATW;
				ST_BT_PATW: begin
					i_q <= i_q + PW'(1);
					state_q <= (i_q + PW'(1) == plen_q) ? ST_KF_INIT : ST_BT_PAT;
				end
				// Failure table
				ST_KF_INIT: begin
					i_q <= '0; j_q <= '1; state_q <= ST_KF_RDI;
				end
				ST_KF_RDI: state_q <= ST_KF_RDJ;
				ST_KF_RDJ: begin
					bi_q <= p_rd; state_q <= ST_KF_CMP;
				end
				ST_KF_CMP: begin
					if (!j_q[FA] && bi_q != p_rd) state_q <= ST_KF_RDF;
					else begin
						i_q <= i_q + PW'(1); j_q <= j_q + (FA+1)'(1);
						state_q <= ST_KF_RDI2;
					end
				end
				ST_KF_RDF: state_q <= ST_KF_FWAIT;
				// follow the failure link, then refetch both bytes
				ST_KF_FWAIT: begin
					j_q <= f_rd; state_q <= ST_KF_RDI;
				end
				ST_KF_RDI2: begin
					if (i_q >= plen_q) state_q <= ST_KF_SET;
					else state_q <= ST_KF_RDJ2;
				end
				ST_KF_RDJ2: begin
					bi_q <= p_rd; state_q <= ST_KF_FJ;
				end
				ST_KF_FJ: begin
					if (bi_q == p_rd) state_q <= ST_KF_STEP;
					else state_q <= ST_KF_SET;
				end
				ST_KF_STEP: state_q <= ST_KF_RDI;
				ST_KF_SET: begin
					if (i_q >= plen_q) begin
						valid_q <= 1'b1; state_q <= ST_F_START;
					end else state_q <= ST_KF_RDI;
				end
				// Search
				ST_F_START: begin
					if (tlen_q < TW'(plen_q) || shift_q > last_w) begin
						res_q.exhausted <= 1'b1; state_q <= ST_RESP;
					end else state_q <= ST_F_LAST;
				end
				ST_F_LAST: state_q <= ST_F_LASTW;
				ST_F_LASTW: state_q <= ST_F_CHK;
				ST_F_CHK: begin
					if (p_rd == t_rd) begin
						i_q <= '0; state_q <= ST_F_CMP;
					end else if (shift_q + plen_x >= tlen_x) begin
						shift_q <= last_w + SW'(1);
						res_q.exhausted <= 1'b1; state_q <= ST_RESP;
					end else state_q <= ST_F_NEXT;
				end
				ST_F_NEXT: state_q <= ST_F_SHW;
				ST_F_SHW: state_q <= ST_F_SHIFT;
				ST_F_SHIFT: begin
					shift_q <= shift_q + SW'(s_rd); state_q <= ST_F_START;
				end
				ST_F_CMP: begin
					if (i_q >= plen_q) state_q <= ST_F_FAIL;
					else state_q <= ST_F_CMPW;
				end
				ST_F_CMPW: state_q <= ST_F_CMPD;
				ST_F_CMPD: begin
					if (p_rd == t_rd) begin
						i_q <= i_q + PW'(1); state_q <= ST_F_CMP;
					end else state_q <= ST_F_FAIL;
				end
				ST_F_FAIL: state_q <= ST_F_FAILW;
				ST_F_FAILW: begin
					shift_q <= shift_q + SW'(SW'(i_q) - SW'(signed'(f_rd)));
					if (i_q >= plen_q) begin
						res_q.found <= 1'b1;
						res_q.match_pos <= 12'(shift_q);
						state_q <= ST_RESP;
					end else state_q <= ST_F_START;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FJS_ASSERT_NEXT(a_resp_strobe, clk, arst_n, state_q == ST_RESP, res_valid && !busy)
	`FJS_ASSERT_IMP(a_one_hot_res, clk, arst_n, res_valid,
		!(res.found && res.exhausted))
	`FJS_ASSERT_IMP(a_len_range, clk, arst_n, 1'b1,
		plen_q != '0 && 32'(plen_q) <= PATTERN_MAX)
	`FJS_ASSERT_IMP(a_tlen_range, clk, arst_n, 1'b1, 32'(tlen_q) <= TEXT_MAX)

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fjs_string_search. A queued driver issues pattern
// writes, text appends, clears and find requests. The pattern length register
// is set over APB between phases. A behavioral search predicts every result
// and the monitor checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import fjs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAT_MAX   = 64;
	localparam int TXT_MAX   = 4096;
	localparam int WDOG_MAX  = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	fjs_req_t    req = '0;
	logic        res_valid;
	fjs_res_t    res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic        paddr = 1'b0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	fjs_string_search u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.res_valid(res_valid), .res(res), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// request stream and expected results
	fjs_req_t pending_reqs[$];
	fjs_res_t expected_res[$];
	int       errors = 0;
	int       idle_pct = 24;
	int       wdog = 0;

	// search state mirror
	logic [7:0] pat_mem[PAT_MAX];
	logic [7:0] txt_mem[TXT_MAX];
	int         skip_tbl[256];
	int         fail_tbl[PAT_MAX + 1];
	int         pat_len = 1;
	int         txt_len = 0;
	int         next_shift = 0;
	bit         tables_ok = 1'b0;

	// generator-side view, used only to shape legal stimulus
	logic [7:0] gen_pat[PAT_MAX];
	bit         gen_written[PAT_MAX];
	int         gen_len = 1;
	int         gen_txt = 0;

	function automatic void rebuild_tables();
		int i;
		int j;
		for (i = 0; i < 256; i++) skip_tbl[i] = pat_len + 1;
		for (i = 0; i < pat_len; i++) skip_tbl[pat_mem[i]] = pat_len - i;
		i = 0;
		j = -1;
		fail_tbl[0] = -1;
		while (i < pat_len) begin
			while (j > -1 && pat_mem[i] != pat_mem[j]) j = fail_tbl[j];
			i++;
			j++;
			if (i < pat_len && pat_mem[i] == pat_mem[j])
				fail_tbl[i] = fail_tbl[j];
			else
				fail_tbl[i] = j;
		end
		tables_ok = 1'b1;
	endfunction

	// next match from the stored shift; returns 1 and the position on a hit
	function automatic bit search_next(output int pos);
		int m;
		int s;
		int last;
		int i;
		int step;
		m = pat_len;
		s = next_shift;
		pos = 0;
		if (!tables_ok) rebuild_tables();
		if (txt_len < m) return 1'b0;
		last = txt_len - m;
		while (s <= last) begin
			while (s <= last && pat_mem[m-1] != txt_mem[s+m-1]) begin
				if (s + m >= txt_len) begin
					s = last + 1;
					break;
				end
				s += skip_tbl[txt_mem[s+m]];
			end
			if (s > last) break;
			i = 0;
			while (i < m && pat_mem[i] == txt_mem[s+i]) i++;
			step = i - fail_tbl[i];
			if (i >= m) begin
				pos = s;
				next_shift = s + step;
				return 1'b1;
			end
			s += step;
		end
		next_shift = s;
		return 1'b0;
	endfunction

	function automatic fjs_res_t search_result(fjs_req_t r);
		fjs_res_t o;
		int       pos;
		o = '0;
		case (r.req_type)
			REQ_PAT: begin
				pat_mem[r.pattern_index] = r.data_byte;
				tables_ok = 1'b0;
				next_shift = 0;
			end
			REQ_TEXT: begin
				if (txt_len < TXT_MAX) begin
					txt_mem[txt_len] = r.data_byte;
					txt_len++;
				end else
					o.text_overflow = 1'b1;
			end
			REQ_CLEAR: begin
				txt_len = 0;
				next_shift = 0;
			end
			default: begin
				if (search_next(pos)) begin
					o.found = 1'b1;
					o.match_pos = pos[11:0];
				end else
					o.exhausted = 1'b1;
			end
		endcase
		return o;
	endfunction

	// driver: holds start until the request is taken
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_res.push_back(search_result(req));
		end
		if (!start || !busy) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				req <= pending_reqs.pop_front();
			end else
				start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		fjs_res_t e;
		if (res_valid) begin
			if (expected_res.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (res.found !== e.found) begin
					$error("found exp %0d got %0d", e.found, res.found);
					errors++;
				end
				if (res.match_pos !== e.match_pos) begin
					$error("match_pos exp %0d got %0d", e.match_pos, res.match_pos);
					errors++;
				end
				if (res.exhausted !== e.exhausted) begin
					$error("exhausted exp %0d got %0d", e.exhausted, res.exhausted);
					errors++;
				end
				if (res.text_overflow !== e.text_overflow) begin
					$error("text_overflow exp %0d got %0d", e.text_overflow,
						res.text_overflow);
					errors++;
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((start && !busy) || res_valid)
			wdog <= 0;
		else if (wdog >= WDOG_MAX) begin
			$display("FAIL fjs_string_search");
			$finish;
		end else
			wdog <= wdog + 1;
	end

	task automatic push_req(logic [1:0] t, logic [5:0] idx, logic [7:0] b);
		fjs_req_t r;
		r.req_type = t;
		r.pattern_index = idx;
		r.data_byte = b;
		pending_reqs.push_back(r);
		if (t == REQ_PAT) begin
			gen_pat[idx] = b;
			gen_written[idx] = 1'b1;
		end else if (t == REQ_TEXT) begin
			if (gen_txt < TXT_MAX) gen_txt++;
		end else if (t == REQ_CLEAR)
			gen_txt = 0;
	endtask

	function automatic bit find_legal();
		for (int i = 0; i < gen_len; i++)
			if (!gen_written[i]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [7:0] text_char();
		if ($urandom_range(9) == 0) return 8'($urandom);
		return 8'h41 + 8'($urandom_range(2));
	endfunction

	// wait until every request is taken and answered
	task automatic drain();
		while (pending_reqs.size() > 0 || start || expected_res.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_len(logic [6:0] v);
		int eff;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 1'b0;
		pwdata <= {25'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		eff = (v == 0) ? 1 : ((v > PAT_MAX) ? PAT_MAX : v);
		pat_len = eff;
		gen_len = eff;
		tables_ok = 1'b0;
		next_shift = 0;
	endtask

	// one random phase of mostly well-formed search sessions
	task automatic random_phase(int n_items);
		int  stop;
		int  k;
		bit  plant;
		stop = pending_reqs.size() + n_items;
		while (pending_reqs.size() < stop) begin
			case ($urandom_range(9))
				0, 1: begin
					for (int i = 0; i < gen_len; i++)
						push_req(REQ_PAT, 6'(i), text_char());
				end
				2, 3, 4, 5: begin
					if (gen_txt > 3000 || $urandom_range(1)) push_req(REQ_CLEAR, '0, 8'($urandom));
					k = $urandom_range(1, 40);
					for (int c = 0; c < k && pending_reqs.size() < stop; c++) begin
						plant = find_legal() && ($urandom_range(5) == 0);
						if (plant)
							for (int i = 0; i < gen_len; i++)
								push_req(REQ_TEXT, 6'($urandom), gen_pat[i]);
						else
							push_req(REQ_TEXT, 6'($urandom), text_char());
					end
					if (find_legal())
						for (int c = $urandom_range(1, 6); c > 0; c--)
							push_req(REQ_FIND, 6'($urandom), 8'($urandom));
				end
				6: begin
					if (find_legal()) push_req(REQ_FIND, 6'($urandom), 8'($urandom));
				end
				default: begin
					// noise: a pattern write, text append or clear with random fields
					k = $urandom_range(2);
					if (gen_txt > 3000) k = REQ_CLEAR;
					push_req(2'(k), 6'($urandom), 8'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		int lens[9];
		lens = '{7'd0, 7'd2, 7'd127, 7'd3, 7'd1, 7'd5, 7'd64, 7'd4, 7'd8};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes, repeat matches, short text
		push_req(REQ_PAT, 6'd0, 8'hFF);
		push_req(REQ_PAT, 6'd63, 8'h00);
		push_req(REQ_FIND, 6'd0, 8'h00);
		push_req(REQ_TEXT, 6'd63, 8'hFF);
		push_req(REQ_TEXT, 6'd0, 8'h00);
		push_req(REQ_TEXT, 6'd0, 8'hFF);
		push_req(REQ_FIND, 6'd0, 8'h00);
		push_req(REQ_FIND, 6'd0, 8'h00);
		push_req(REQ_FIND, 6'd0, 8'h00);
		push_req(REQ_TEXT, 6'd0, 8'hFF);
		push_req(REQ_FIND, 6'd0, 8'h00);
		push_req(REQ_CLEAR, 6'd0, 8'h00);
		push_req(REQ_FIND, 6'd0, 8'h00);
		push_req(REQ_PAT, 6'd0, 8'h12);
		push_req(REQ_TEXT, 6'd0, 8'h12);
		push_req(REQ_FIND, 6'd0, 8'h00);
		drain();

		for (int p = 0; p < 9; p++) begin
			idle_pct = (p < 3) ? 24 : ((p < 6) ? 69 : 0);
			write_len(7'(lens[p]));
			random_phase(170);
			drain();
		end

		if (errors == 0)
			$display("PASS fjs_string_search");
		else
			$display("FAIL fjs_string_search");
		$finish;
	end

endmodule

// ===== fjs_string_search.f =====
+incdir+rtl
rtl/fjs_pkg.sv
rtl/fjs_ram.sv
rtl/fjs_string_search.sv
tb/testbench.sv
